// File: sv/trdc_pkg.sv
package trdc_pkg;

   localparam int IDX_W       = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_DONE  = 2'd1;
   localparam logic [1:0] CMD_ERROR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_DONE,
      OP_ERROR,
      OP_READ
   } op_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [7:0]       data_byte;
      logic             message_end;
      logic [IDX_W-1:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic             launch_valid;
      logic [IDX_W-1:0] launch_start;
      logic [IDX_W-1:0] launch_length;
      logic             byte_accepted;
      logic [7:0]       read_data;
      logic [31:0]      dropped_total;
      logic [31:0]      overflow_total;
      logic [31:0]      error_total;
   } rsp_word_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       data_byte;
      logic             message_end;
      logic [IDX_W-1:0] read_index;
      logic [IDX_W-1:0] read_quot;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// File: sv/trdc_front.sv
module trdc_front #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  trdc_pkg::req_word_type req_word,
   input  logic                  queue_full,
   output trdc_pkg::push_type    push
);

   localparam int L_W  = $clog2(RING_DEPTH);
   localparam int SH   = trdc_pkg::IDX_W + L_W;
   localparam int MULT = ((1 << SH) + RING_DEPTH - 1) / RING_DEPTH;
   localparam int M_W  = $clog2(MULT + 1);
   localparam int P_W  = trdc_pkg::IDX_W + M_W;

   logic                accept;
   logic                valid_ff;
   logic                valid_in;
   trdc_pkg::entry_type entry_ff;
   trdc_pkg::entry_type entry_in;
   trdc_pkg::entry_type decoded;
   logic [P_W-1:0]      prod;

   assign busy   = reset | (valid_ff & queue_full);
   assign accept = start & ~busy;

   // The quotient of the read index by the ring depth, exact for every ten-bit index.
   assign prod = P_W'(req_word.read_index) * P_W'(MULT);

   always_comb begin
      decoded.data_byte   = req_word.data_byte;
      decoded.message_end = req_word.message_end;
      decoded.read_index  = req_word.read_index;
      decoded.read_quot   = trdc_pkg::IDX_W'(prod >> SH);
      unique case (req_word.command)
         trdc_pkg::CMD_WRITE: decoded.op = trdc_pkg::OP_STORE;
         trdc_pkg::CMD_DONE:  decoded.op = trdc_pkg::OP_DONE;
         trdc_pkg::CMD_ERROR: decoded.op = trdc_pkg::OP_ERROR;
         trdc_pkg::CMD_READ:  decoded.op = trdc_pkg::OP_READ;
         default:             decoded.op = trdc_pkg::OP_READ;
      endcase
   end

   assign valid_in = accept | (valid_ff & queue_full);
   assign entry_in = accept ? decoded : entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push.valid = valid_ff & ~queue_full;
   assign push.entry = entry_ff;

endmodule

// File: sv/trdc_queue.sv
module trdc_queue (
   input  logic                clock,
   input  logic                reset,
   input  trdc_pkg::push_type  push,
   output logic                full,
   output logic                pop_valid,
   output trdc_pkg::entry_type pop_entry
);

   localparam int QD = trdc_pkg::QUEUE_DEPTH;
   localparam int PW = trdc_pkg::QPTR_W;

   trdc_pkg::entry_type entries_ff [QD];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff;
   logic [PW-1:0]       rd_ptr_in;
   logic [PW:0]         count_ff;
   logic [PW:0]         count_in;

   assign full      = (count_ff == (PW+1)'(QD));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_valid ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push.valid) - (PW+1)'(pop_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// File: sv/trdc_back.sv
module trdc_back #(
   parameter int RING_DEPTH = 1024,
   parameter int BURST_MAX  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  trdc_pkg::entry_type    item,
   output logic                   rsp_valid,
   output trdc_pkg::rsp_word_type rsp_word
);

   localparam int PW = $clog2(RING_DEPTH);
   localparam int CW = PW + 1;
   localparam int BW = $clog2(BURST_MAX + 1);
   localparam int IW = trdc_pkg::IDX_W;
   localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
   localparam logic [BW-1:0] BURST_C  = BW'(BURST_MAX);

   logic [7:0]    ring_ff [RING_DEPTH];

   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [PW-1:0] flight_ff, flight_in;
   logic          xbusy_ff, xbusy_in;
   logic [BW-1:0] burst_ff, burst_in;
   logic          disc_ff, disc_in;
   logic [31:0]   drop_ff, drop_in;
   logic [31:0]   ovf_ff, ovf_in;
   logic [31:0]   err_ff, err_in;

   logic          rsp_valid_ff;
   logic          launch_ff, launch_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] length_ff, length_in;
   logic          accepted_ff, accepted_in;
   logic          is_read_ff, read_en;
   logic [7:0]    read_data_ff;

   logic [PW-1:0] wr_inc, wr_inc2, rd_adv, rd_addr;
   logic [CW-1:0] rd_sum, span;
   logic [BW-1:0] burst_inc;
   logic [IW-1:0] idx_base, idx_mod;
   logic          ring_full, full_after, store_en, try_launch;

   assign wr_inc     = (wr_ff == LAST_POS) ? '0 : wr_ff + 1'b1;
   assign wr_inc2    = (wr_inc == LAST_POS) ? '0 : wr_inc + 1'b1;
   assign ring_full  = (wr_inc == rd_ff);
   assign full_after = (wr_inc2 == rd_ff);
   assign burst_inc  = burst_ff + 1'b1;
   assign rd_sum     = CW'(rd_ff) + CW'(flight_ff);
   assign rd_adv     = (rd_sum >= DEPTH_C) ? PW'(rd_sum - DEPTH_C) : PW'(rd_sum);
   assign idx_base   = IW'(item.read_quot * RING_DEPTH);
   assign idx_mod    = item.read_index - idx_base;
   assign rd_addr    = PW'(idx_mod);

   always_comb begin
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      flight_in   = flight_ff;
      xbusy_in    = xbusy_ff;
      burst_in    = burst_ff;
      disc_in     = disc_ff;
      drop_in     = drop_ff;
      ovf_in      = ovf_ff;
      err_in      = err_ff;
      store_en    = 1'b0;
      accepted_in = 1'b0;
      try_launch  = 1'b0;
      read_en     = 1'b0;
      if (item_valid) begin
         case (item.op)
            trdc_pkg::OP_STORE: begin
               if (disc_ff) begin
                  drop_in = drop_ff + 32'd1;
                  if (item.message_end) begin
                     disc_in = 1'b0;
                  end
               end else if (ring_full) begin
                  ovf_in   = ovf_ff + 32'd1;
                  drop_in  = drop_ff + 32'd1;
                  burst_in = '0;
                  disc_in  = ~item.message_end;
               end else begin
                  store_en    = 1'b1;
                  accepted_in = 1'b1;
                  wr_in       = wr_inc;
                  burst_in    = burst_inc;
                  if (burst_inc >= BURST_C || full_after || item.message_end) begin
                     burst_in   = '0;
                     try_launch = 1'b1;
                  end
               end
            end
            trdc_pkg::OP_DONE: begin
               rd_in      = rd_adv;
               flight_in  = '0;
               xbusy_in   = 1'b0;
               try_launch = 1'b1;
            end
            trdc_pkg::OP_ERROR: begin
               err_in     = err_ff + 32'd1;
               flight_in  = '0;
               xbusy_in   = 1'b0;
               try_launch = 1'b1;
            end
            default: begin
               read_en = 1'b1;
            end
         endcase
      end

      span = (wr_in >= rd_in) ? CW'(wr_in - rd_in) : DEPTH_C - CW'(rd_in);
      launch_in = try_launch & ~xbusy_in & (span != '0);
      start_in  = '0;
      length_in = '0;
      if (launch_in) begin
         xbusy_in  = 1'b1;
         flight_in = PW'(span);
         start_in  = IW'(rd_in);
         length_in = IW'(span);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         flight_ff    <= '0;
         xbusy_ff     <= 1'b0;
         burst_ff     <= '0;
         disc_ff      <= 1'b0;
         drop_ff      <= '0;
         ovf_ff       <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         flight_ff    <= flight_in;
         xbusy_ff     <= xbusy_in;
         burst_ff     <= burst_in;
         disc_ff      <= disc_in;
         drop_ff      <= drop_in;
         ovf_ff       <= ovf_in;
         err_ff       <= err_in;
         rsp_valid_ff <= item_valid;
      end
      launch_ff   <= launch_in;
      start_ff    <= start_in;
      length_ff   <= length_in;
      accepted_ff <= accepted_in;
      is_read_ff  <= read_en;
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         ring_ff[wr_ff] <= item.data_byte;
      end
      if (read_en) begin
         read_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_word.launch_valid   = launch_ff;
   assign rsp_word.launch_start   = start_ff;
   assign rsp_word.launch_length  = length_ff;
   assign rsp_word.byte_accepted  = accepted_ff;
   assign rsp_word.read_data      = is_read_ff ? read_data_ff : 8'd0;
   assign rsp_word.dropped_total  = drop_ff;
   assign rsp_word.overflow_total = ovf_ff;
   assign rsp_word.error_total    = err_ff;

endmodule

// File: sv/tx_ring_dma_chunker.sv
// Each accepted word passes through the front register, the queue and the back-end
// response registers before its result strobe rises.
// One word is taken per cycle: the back end executes a queued word every cycle,
// so busy is high only while reset is asserted and the strobe cannot be held off.
// Synchronous reset clears the pointers, the flight state and the counters;
// ring contents are not cleared and read as undefined until written.
module tx_ring_dma_chunker #(
   parameter int RING_DEPTH = 1024,
   parameter int BURST_MAX  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  trdc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output trdc_pkg::rsp_word_type rsp_word
);

   trdc_pkg::push_type  push;
   trdc_pkg::entry_type pop_entry;
   logic                queue_full;
   logic                pop_valid;

   trdc_front #(
      .RING_DEPTH(RING_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .queue_full (queue_full),
      .push       (push)
   );

   trdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry)
   );

   trdc_back #(
      .RING_DEPTH(RING_DEPTH),
      .BURST_MAX (BURST_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

endmodule

// File: sv/trdc_checker.sv
module trdc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input trdc_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input trdc_pkg::rsp_word_type rsp_word
);

   logic accept;

   assign accept = start & ~busy;

   // Every accepted word gives exactly one result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("accepted word produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without an accepted word");

   // A launch always carries at least one byte.
   a_launch_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.launch_valid) |-> (rsp_word.launch_length != '0))
      else $error("launch with zero length");

   // A read result only follows a read command.
   a_read_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.read_data != 8'd0)
         |-> ($past(req_word.command, 3) == trdc_pkg::CMD_READ))
      else $error("read data on a non-read result");

endmodule

bind tx_ring_dma_chunker trdc_checker u_trdc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
